// File: design/lva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lva_pkg
// Types and constants shared by the look-at view matrix block.
// ----------------------------------------------------------------------------
package lva_pkg;

    localparam logic signed [31:0] ONE_Q16      = 32'sh0001_0000;
    localparam logic [66:0]        NEAR_ZERO_SQ = 67'd4295;
    localparam int                 MUL_BITS     = 32;
    localparam int                 DIV_BITS     = 47;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM_ABS,
        S_NORM_SHIFT,
        S_MUL_LOAD,
        S_MUL_RUN,
        S_MUL_ACC,
        S_SQRT,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_DIV_STORE,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_NEAR,
        PH_SQ,
        PH_CROSS,
        PH_DOT
    } t_phase;

    typedef enum logic [1:0] {
        AX_FWD,
        AX_RGT,
        AX_UP
    } t_axis;

    typedef struct packed {
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic        sgn;
        logic        first;
        logic        last;
        logic        done;
        logic [1:0]  dst;
    } t_mop;

endpackage

// File: design/look_at_view_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Builds a look-at view matrix in Q16.16 and emits it one row at a time, four rows per request.
// ----------------------------------------------------------------------------
// Work: nine bit-serial products without reaim; with reaim, also three
//   normalisations (each scaled by single-bit shifts), two squares for the
//   near-vertical test and six cross products.
// Throughput: one request at a time; the next is taken once row 3 has left.
// Rate is set by the shared one-bit-per-cycle multiplier, root and divider.
// Reset (synchronous, active low) restores the default camera axes and idles.
// ----------------------------------------------------------------------------
module look_at_view_matrix
    import lva_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_z,
    input  logic               i_reaim,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_row_index,
    output logic signed [31:0] o_col0,
    output logic signed [31:0] o_col1,
    output logic signed [31:0] o_col2,
    output logic signed [31:0] o_col3,
    output logic               o_last_row
);

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(32'd0 - v) : 32'(v);
    endfunction

    function automatic logic signed [31:0] sat51(input logic signed [50:0] v);
        if (v > 51'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -51'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // state
    t_state r_state, n_state;
    t_phase r_phase;
    t_axis  r_ndest;

    // camera axes and position
    logic signed [31:0] r_fwd [3];
    logic signed [31:0] r_rgt [3];
    logic signed [31:0] r_up  [3];
    logic signed [31:0] r_p   [3];
    logic signed [31:0] r_d   [3];

    // normaliser working set
    logic signed [63:0] r_w   [3];
    logic        [63:0] r_mag [3];
    logic        [2:0]  r_neg;

    // serial units
    logic [3:0]         r_k;
    logic [5:0]         r_cnt;
    logic [63:0]        r_ma;
    logic [31:0]        r_mb;
    logic [63:0]        r_prod;
    logic               r_sgn;
    logic signed [66:0] r_acc;
    logic [63:0]        r_x;
    logic [63:0]        r_res;
    logic [63:0]        r_bit;
    logic [31:0]        r_len;
    logic [46:0]        r_num;
    logic [32:0]        r_rem;
    logic [31:0]        r_q;
    logic [1:0]         r_i;
    logic [1:0]         r_row;

    t_mop               op;
    logic               w_zero, w_shr, w_shl;
    logic signed [66:0] acc_new;
    logic signed [50:0] dot_q;
    logic signed [31:0] dot_v;
    logic [32:0]        rem_sh;
    logic signed [31:0] div_v;
    logic [63:0]        sq_try;

    // operand selection for the shared multiplier
    always_comb begin
        logic signed [31:0] a, b;
        logic               ng;
        a  = '0;
        b  = '0;
        ng = 1'b0;
        op = '0;
        case (r_phase)
            PH_NEAR: begin
                a = (r_k == 4'd0) ? r_fwd[0] : r_fwd[2];
                b = a;
                op.first = (r_k == 4'd0);
                op.last  = (r_k == 4'd1);
                op.done  = (r_k == 4'd1);
            end
            PH_SQ: begin
                a = (r_k == 4'd0) ? r_mag[0][31:0] :
                    (r_k == 4'd1) ? r_mag[1][31:0] : r_mag[2][31:0];
                b = a;
                op.first = (r_k == 4'd0);
                op.last  = (r_k == 4'd2);
                op.done  = (r_k == 4'd2);
            end
            PH_CROSS: begin
                case (r_k)
                    4'd0: begin a = r_fwd[1]; b = r_rgt[2]; end
                    4'd1: begin a = r_fwd[2]; b = r_rgt[1]; ng = 1'b1; end
                    4'd2: begin a = r_fwd[2]; b = r_rgt[0]; end
                    4'd3: begin a = r_fwd[0]; b = r_rgt[2]; ng = 1'b1; end
                    4'd4: begin a = r_fwd[0]; b = r_rgt[1]; end
                    default: begin a = r_fwd[1]; b = r_rgt[0]; ng = 1'b1; end
                endcase
                op.first = ~r_k[0];
                op.last  = r_k[0];
                op.done  = (r_k == 4'd5);
                op.dst   = 2'(r_k >> 1);
            end
            default: begin
                case (r_k)
                    4'd0: begin a = r_rgt[0]; b = r_p[0]; end
                    4'd1: begin a = r_rgt[1]; b = r_p[1]; end
                    4'd2: begin a = r_rgt[2]; b = r_p[2]; end
                    4'd3: begin a = r_up[0];  b = r_p[0]; end
                    4'd4: begin a = r_up[1];  b = r_p[1]; end
                    4'd5: begin a = r_up[2];  b = r_p[2]; end
                    4'd6: begin a = r_fwd[0]; b = r_p[0]; end
                    4'd7: begin a = r_fwd[1]; b = r_p[1]; end
                    default: begin a = r_fwd[2]; b = r_p[2]; end
                endcase
                op.first = (r_k == 4'd0) || (r_k == 4'd3) || (r_k == 4'd6);
                op.last  = (r_k == 4'd2) || (r_k == 4'd5) || (r_k == 4'd8);
                op.done  = (r_k == 4'd8);
                op.dst   = (r_k < 4'd3) ? 2'd0 : (r_k < 4'd6) ? 2'd1 : 2'd2;
            end
        endcase
        op.mag_a = mag32(a);
        op.mag_b = mag32(b);
        op.sgn   = a[31] ^ b[31] ^ ng;
    end

    // shared datapath flags
    always_comb begin
        w_zero  = (r_w[0] == '0) && (r_w[1] == '0) && (r_w[2] == '0);
        w_shr   = (r_mag[0][63:30] != '0) || (r_mag[1][63:30] != '0) ||
                  (r_mag[2][63:30] != '0);
        w_shl   = (r_mag[0][63:29] == '0) && (r_mag[1][63:29] == '0) &&
                  (r_mag[2][63:29] == '0);
        acc_new = r_sgn ? r_acc - $signed({3'b000, r_prod})
                        : r_acc + $signed({3'b000, r_prod});
        dot_q   = 51'((acc_new + 67'sd32768) >>> 16);
        dot_v   = sat51((op.dst == 2'd2) ? dot_q : -dot_q);
        rem_sh  = {r_rem[31:0], r_num[46]};
        div_v   = r_neg[r_i] ? 32'(32'd0 - r_q) : r_q;
        sq_try  = r_res + r_bit;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = i_reaim ? S_NORM_ABS : S_MUL_LOAD;
                end
            end
            S_NORM_ABS: begin
                if (w_zero) begin
                    n_state = (r_ndest == AX_FWD || r_ndest == AX_RGT) ? S_MUL_LOAD
                                                                         : S_MUL_LOAD;
                end else begin
                    n_state = S_NORM_SHIFT;
                end
            end
            S_NORM_SHIFT: begin
                if (!w_shr && !w_shl) begin
                    n_state = S_MUL_LOAD;
                end
            end
            S_MUL_LOAD: n_state = S_MUL_RUN;
            S_MUL_RUN: begin
                if (r_cnt == 6'(MUL_BITS - 1)) begin
                    n_state = S_MUL_ACC;
                end
            end
            S_MUL_ACC: begin
                if (!op.done) begin
                    n_state = S_MUL_LOAD;
                end else begin
                    case (r_phase)
                        PH_NEAR:  n_state = S_NORM_ABS;
                        PH_SQ:    n_state = S_SQRT;
                        PH_CROSS: n_state = S_NORM_ABS;
                        default:  n_state = S_EMIT;
                    endcase
                end
            end
            S_SQRT: begin
                if (r_bit == '0) begin
                    n_state = S_DIV_LOAD;
                end
            end
            S_DIV_LOAD: n_state = S_DIV_RUN;
            S_DIV_RUN: begin
                if (r_cnt == 6'(DIV_BITS - 1)) begin
                    n_state = S_DIV_STORE;
                end
            end
            S_DIV_STORE: begin
                n_state = (r_i == 2'd2) ? S_MUL_LOAD : S_DIV_LOAD;
            end
            S_EMIT: begin
                if (i_ready && r_row == 2'd3) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // handshake and row outputs
    always_comb begin
        o_ready     = (r_state == S_IDLE);
        o_valid     = (r_state == S_EMIT);
        o_row_index = r_row;
        o_last_row  = (r_row == 2'd3);
        case (r_row)
            2'd0: begin
                o_col0 = r_rgt[0]; o_col1 = r_rgt[1]; o_col2 = r_rgt[2]; o_col3 = r_d[0];
            end
            2'd1: begin
                o_col0 = r_up[0]; o_col1 = r_up[1]; o_col2 = r_up[2]; o_col3 = r_d[1];
            end
            2'd2: begin
                o_col0 = (r_fwd[0] == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -r_fwd[0];
                o_col1 = (r_fwd[1] == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -r_fwd[1];
                o_col2 = (r_fwd[2] == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -r_fwd[2];
                o_col3 = r_d[2];
            end
            default: begin
                o_col0 = '0; o_col1 = '0; o_col2 = '0; o_col3 = ONE_Q16;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_fwd[0] <= '0;      r_fwd[1] <= '0;      r_fwd[2] <= -ONE_Q16;
            r_rgt[0] <= ONE_Q16; r_rgt[1] <= '0;      r_rgt[2] <= '0;
            r_up[0]  <= '0;      r_up[1]  <= ONE_Q16; r_up[2]  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_p[0] <= i_pos_x;
                        r_p[1] <= i_pos_y;
                        r_p[2] <= i_pos_z;
                        r_w[0] <= 64'(33'(i_target_x) - 33'(i_pos_x));
                        r_w[1] <= 64'(33'(i_target_y) - 33'(i_pos_y));
                        r_w[2] <= 64'(33'(i_target_z) - 33'(i_pos_z));
                        r_ndest <= AX_FWD;
                        r_phase <= PH_DOT;
                        r_k     <= '0;
                    end
                end
                S_NORM_ABS: begin
                    for (int j = 0; j < 3; j++) begin
                        r_neg[j] <= r_w[j][63];
                        r_mag[j] <= r_w[j][63] ? 64'(64'd0 - r_w[j]) : 64'(r_w[j]);
                    end
                    if (w_zero) begin
                        // zero length: store a zero axis and move on
                        for (int j = 0; j < 3; j++) begin
                            case (r_ndest)
                                AX_FWD:  r_fwd[j] <= '0;
                                AX_RGT:  r_rgt[j] <= '0;
                                default: r_up[j]  <= '0;
                            endcase
                        end
                        r_k     <= '0;
                        r_phase <= (r_ndest == AX_FWD) ? PH_NEAR :
                                   (r_ndest == AX_RGT) ? PH_CROSS : PH_DOT;
                    end
                end
                S_NORM_SHIFT: begin
                    for (int j = 0; j < 3; j++) begin
                        if (w_shr) begin
                            r_mag[j] <= r_mag[j] >> 1;
                        end else if (w_shl) begin
                            r_mag[j] <= r_mag[j] << 1;
                        end
                    end
                    r_phase <= PH_SQ;
                    r_k     <= '0;
                end
                S_MUL_LOAD: begin
                    r_ma   <= {32'd0, op.mag_a};
                    r_mb   <= op.mag_b;
                    r_sgn  <= op.sgn;
                    r_prod <= '0;
                    r_cnt  <= '0;
                    if (op.first) begin
                        r_acc <= '0;
                    end
                end
                S_MUL_RUN: begin
                    // advance one multiplier bit per cycle
                    if (r_mb[0]) begin
                        r_prod <= r_prod + r_ma;
                    end
                    r_ma  <= r_ma << 1;
                    r_mb  <= r_mb >> 1;
                    r_cnt <= r_cnt + 6'd1;
                end
                S_MUL_ACC: begin
                    r_acc <= acc_new;
                    r_k   <= r_k + 4'd1;
                    case (r_phase)
                        PH_NEAR: begin
                            if (acc_new < $signed(NEAR_ZERO_SQ)) begin
                                r_w[0] <= '0;
                                r_w[1] <= -64'(r_fwd[2]);
                                r_w[2] <= 64'(r_fwd[1]);
                            end else begin
                                r_w[0] <= 64'(r_fwd[2]);
                                r_w[1] <= '0;
                                r_w[2] <= -64'(r_fwd[0]);
                            end
                            if (op.done) begin
                                r_ndest <= AX_RGT;
                            end
                        end
                        PH_SQ: begin
                            r_x   <= acc_new[63:0];
                            r_res <= '0;
                            r_bit <= 64'd1 << 62;
                        end
                        PH_CROSS: begin
                            if (op.last) begin
                                r_w[op.dst] <= acc_new[63:0];
                            end
                            if (op.done) begin
                                r_ndest <= AX_UP;
                            end
                        end
                        default: begin
                            if (op.last) begin
                                r_d[op.dst] <= dot_v;
                            end
                            r_row <= '0;
                        end
                    endcase
                end
                S_SQRT: begin
                    if (r_bit != '0) begin
                        if (r_x >= sq_try) begin
                            r_x   <= r_x - sq_try;
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end else begin
                        r_len <= r_res[31:0];
                        r_i   <= '0;
                    end
                end
                S_DIV_LOAD: begin
                    r_num <= {1'b0, r_mag[r_i][29:0], 16'd0} + 47'(r_len >> 1);
                    r_rem <= '0;
                    r_q   <= '0;
                    r_cnt <= '0;
                end
                S_DIV_RUN: begin
                    // one quotient bit per cycle
                    if (rem_sh >= {1'b0, r_len}) begin
                        r_rem <= rem_sh - {1'b0, r_len};
                        r_q   <= {r_q[30:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_q   <= {r_q[30:0], 1'b0};
                    end
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt + 6'd1;
                end
                S_DIV_STORE: begin
                    case (r_ndest)
                        AX_FWD:  r_fwd[r_i] <= div_v;
                        AX_RGT:  r_rgt[r_i] <= div_v;
                        default: r_up[r_i]  <= div_v;
                    endcase
                    r_i <= r_i + 2'd1;
                    if (r_i == 2'd2) begin
                        r_k     <= '0;
                        r_phase <= (r_ndest == AX_FWD) ? PH_NEAR :
                                   (r_ndest == AX_RGT) ? PH_CROSS : PH_DOT;
                    end
                end
                S_EMIT: begin
                    if (i_ready) begin
                        r_row <= r_row + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input and output sides open together");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_row == (o_row_index == 2'd3)))
        else $error("last_row flag out of step with row index");

    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_row) |=> o_ready)
        else $error("block not idle after the last row");

    a_first_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid)) |-> (o_row_index == 2'd0))
        else $error("matrix output did not start at row 0");

endmodule

// File: verif/lva_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lva_checker
// Watches both channels of the look-at view matrix block, predicts the four
// rows of every accepted request and compares each returned row with them.
// ----------------------------------------------------------------------------
module lva_checker
    import lva_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_z,
    input  logic               i_reaim,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic [1:0]         o_row_index,
    input  logic signed [31:0] o_col0,
    input  logic signed [31:0] o_col1,
    input  logic signed [31:0] o_col2,
    input  logic signed [31:0] o_col3,
    input  logic               o_last_row,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_rows_seen
);

    typedef struct packed {
        logic [1:0]         idx;
        logic signed [31:0] c0;
        logic signed [31:0] c1;
        logic signed [31:0] c2;
        logic signed [31:0] c3;
        logic               last;
    } t_row;

    typedef logic signed [31:0] t_vec [3];
    typedef logic signed [63:0] t_wide [3];

    t_row  rows_due [$];
    t_vec  fwd, rgt, upv;

    function automatic logic [63:0] root64(logic [63:0] x);
        logic [63:0] res, bits;
        res  = 0;
        bits = 64'h1 << 62;
        while (bits > x) bits = bits >> 2;
        while (bits != 0) begin
            if (x >= res + bits) begin
                x   = x - (res + bits);
                res = (res >> 1) + bits;
            end else begin
                res = res >> 1;
            end
            bits = bits >> 2;
        end
        return res;
    endfunction

    function automatic t_vec unit_vec(t_wide v);
        logic [63:0] mag [3];
        logic        neg [3];
        logic [63:0] m, sum, len, q;
        t_vec        r;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? -v[i] : v[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            r[0] = 0; r[1] = 0; r[2] = 0;
            return r;
        end
        while (m >= (64'h1 << 30)) begin
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
            m = m >> 1;
        end
        while (m < (64'h1 << 29)) begin
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            m = m << 1;
        end
        sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        len = root64(sum);
        for (int i = 0; i < 3; i++) begin
            q    = (mag[i] * 64'd65536 + (len >> 1)) / len;
            r[i] = neg[i] ? -q[31:0] : q[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clip32(logic signed [65:0] v);
        if (v > 66'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -66'sh8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Q32.32 dot product, rounded half up to Q16.16, optionally negated.
    function automatic logic signed [31:0] dot_q16(t_vec a, t_wide p, logic negate);
        logic signed [65:0] s, t, q;
        s = 66'(a[0]) * 66'(p[0]) + 66'(a[1]) * 66'(p[1]) + 66'(a[2]) * 66'(p[2]);
        t = s + 66'sd32768;
        q = t >>> 16;
        return clip32(negate ? -q : q);
    endfunction

    task automatic predict_matrix();
        t_wide p, w;
        p[0] = i_pos_x; p[1] = i_pos_y; p[2] = i_pos_z;
        if (i_reaim) begin
            w[0] = 64'(i_target_x) - p[0];
            w[1] = 64'(i_target_y) - p[1];
            w[2] = 64'(i_target_z) - p[2];
            fwd = unit_vec(w);
            // fall back to world X when forward is nearly vertical
            if (64'(fwd[0]) * fwd[0] + 64'(fwd[2]) * fwd[2] < 64'sd4295) begin
                w[0] = 0; w[1] = -64'(fwd[2]); w[2] = fwd[1];
            end else begin
                w[0] = fwd[2]; w[1] = 0; w[2] = -64'(fwd[0]);
            end
            rgt = unit_vec(w);
            w[0] = 64'(fwd[1]) * rgt[2] - 64'(fwd[2]) * rgt[1];
            w[1] = 64'(fwd[2]) * rgt[0] - 64'(fwd[0]) * rgt[2];
            w[2] = 64'(fwd[0]) * rgt[1] - 64'(fwd[1]) * rgt[0];
            upv = unit_vec(w);
        end
        rows_due.push_back('{2'd0, rgt[0], rgt[1], rgt[2], dot_q16(rgt, p, 1'b1), 1'b0});
        rows_due.push_back('{2'd1, upv[0], upv[1], upv[2], dot_q16(upv, p, 1'b1), 1'b0});
        rows_due.push_back('{2'd2, clip32(-66'(fwd[0])), clip32(-66'(fwd[1])),
                            clip32(-66'(fwd[2])), dot_q16(fwd, p, 1'b0), 1'b0});
        rows_due.push_back('{2'd3, 32'sd0, 32'sd0, 32'sd0, ONE_Q16, 1'b1});
    endtask

    task automatic check_row();
        t_row e;
        if (rows_due.size() == 0) begin
            $error("row %0d arrived with nothing expected", o_row_index);
            o_fail_count++;
            return;
        end
        e = rows_due.pop_front();
        if (o_row_index !== e.idx) begin
            $error("row_index expected %0d actual %0d", e.idx, o_row_index);
            o_fail_count++;
        end
        if (o_col0 !== e.c0) begin
            $error("col0 expected %h actual %h", e.c0, o_col0);
            o_fail_count++;
        end
        if (o_col1 !== e.c1) begin
            $error("col1 expected %h actual %h", e.c1, o_col1);
            o_fail_count++;
        end
        if (o_col2 !== e.c2) begin
            $error("col2 expected %h actual %h", e.c2, o_col2);
            o_fail_count++;
        end
        if (o_col3 !== e.c3) begin
            $error("col3 expected %h actual %h", e.c3, o_col3);
            o_fail_count++;
        end
        if (o_last_row !== e.last) begin
            $error("last_row expected %0d actual %0d", e.last, o_last_row);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fwd = '{32'sd0, 32'sd0, -ONE_Q16};
            rgt = '{ONE_Q16, 32'sd0, 32'sd0};
            upv = '{32'sd0, ONE_Q16, 32'sd0};
            rows_due.delete();
            o_fail_count = 0;
            o_rows_seen  = 0;
        end else begin
            if (o_valid && i_ready) begin
                check_row();
                o_rows_seen++;
            end
            if (i_valid && o_ready) predict_matrix();
        end
        o_pending = rows_due.size();
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives look-at requests into the view matrix block under several idling
// patterns and lets the checker compare every row against its prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import lva_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 1500;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [31:0] i_target_x, i_target_y, i_target_z;
    logic               i_reaim;
    logic               o_valid;
    logic               i_ready;
    logic [1:0]         o_row_index;
    logic signed [31:0] o_col0, o_col1, o_col2, o_col3;
    logic               o_last_row;

    int fail_count, pending, rows_seen;
    int send_idle_pct, recv_stall_pct;
    int requests_sent, idle_cycles;

    look_at_view_matrix DUT (.*);

    lva_checker u_checker (
        .*,
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_rows_seen (rows_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Stall the result side at random; the rate follows the current phase.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Count cycles with no handshake on either side; give up at the limit.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("[look_at_view_matrix] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Hold one request until accepted, with a random gap ahead of it.
    // Valid stays high after acceptance unless a gap follows; drop it then.
    task automatic send_request(logic signed [31:0] px, py, pz, tx, ty, tz, logic ra);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_pos_x    <= px;
        i_pos_y    <= py;
        i_pos_z    <= pz;
        i_target_x <= tx;
        i_target_y <= ty;
        i_target_z <= tz;
        i_reaim    <= ra;
        i_valid    <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        requests_sent++;
    endtask

    // Pick a coordinate: mostly moderate, sometimes full range or an extreme.
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh8000_0000;
            3:       return $signed($urandom_range(8191)) - 4096;
            default: return $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
        endcase
    endfunction

    task automatic random_request();
        logic signed [31:0] px, py, pz;
        px = rand_coord(); py = rand_coord(); pz = rand_coord();
        case ($urandom_range(9))
            // target straight above or below: forward along world up
            0: send_request(px, py, pz, px, rand_coord(), pz, 1'b1);
            // target on the camera
            1: send_request(px, py, pz, px, py, pz, 1'b1);
            // keep stored axes
            2, 3: send_request(px, py, pz, rand_coord(), rand_coord(), rand_coord(), 1'b0);
            default: send_request(px, py, pz, rand_coord(), rand_coord(), rand_coord(),
                                  1'b1);
        endcase
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_pos_x = 0; i_pos_y = 0; i_pos_z = 0;
        i_target_x = 0; i_target_y = 0; i_target_z = 0;
        i_reaim = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        requests_sent  = 0;
        idle_cycles    = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset axes first, then the corner cases.
        send_request(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 0, 0, 0, 1'b0);
        send_request(0, 0, 0, 0, 0, 32'shFFFF_0000, 1'b1);
        send_request(0, 0, 0, 0, 32'sh0005_0000, 0, 1'b1);
        send_request(0, 0, 0, 0, -32'sh0005_0000, 0, 1'b1);
        send_request(0, 0, 0, 32'sd10, 32'sh0100_0000, 0, 1'b1);
        send_request(32'sh0123_4567, 0, 0, 32'sh0123_4567, 0, 0, 1'b1);
        send_request(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                     32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
        send_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                     32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
        send_request(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0, 1'b0);
        send_request(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 1'b0);
        send_request(0, 0, 0, 32'sd1, 32'sd1, 32'sd1, 1'b1);
        send_request(32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF,
                     32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001, 1'b1);
        send_request(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                     32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b1);

        // Random phases: free flow, slow sender, slow receiver, both.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            repeat (100) random_request();
        end
        i_valid <= 1'b0;

        // Drain every outstanding row, then give the block a little longer.
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d look-at requests over four idling phases; %0d rows compared.",
                 requests_sent, rows_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("[look_at_view_matrix] OK");
        end else begin
            $display("[look_at_view_matrix] ERROR");
        end
        $finish;
    end

endmodule

// File: look_at_view_matrix.f
design/lva_pkg.sv
design/look_at_view_matrix.sv
verif/lva_checker.sv
verif/tb_top.sv
